### hw/rtl/circle_circle_intersection_macros.svh
// assertion macros for the circle intersection checker
`ifndef CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH
`define CIRCLE_CIRCLE_INTERSECTION_MACROS_SVH

// condition holds at every clock edge out of reset
`define CCI_ASSERT_ALWAYS(lbl, cond, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (cond)) else $error(msg);

// consequent holds in the same cycle as the antecedent
`define CCI_ASSERT_IMPLIES(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) else $error(msg);

`endif

### hw/rtl/cci_pkg.sv
// shared constants for the circle intersection pipeline
`default_nettype none
package cci_pkg;
	// default coordinate width
	localparam int COORD_BITS_DEF = 32;
	// multiplier operand slice handled per pipeline stage
	localparam int MUL_CHUNK = 16;
	// quotient bits kept by the dividers, magnitude clamps to 2^(QUOT_BITS-1)
	localparam int QUOT_BITS = 61;
endpackage
`default_nettype wire

### hw/rtl/cci_delay.sv
// shift line that carries a valid bit and a side bundle
`default_nettype none
module cci_delay #(
	parameter int W = 8,
	parameter int D = 1
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         vin,
	input  logic [W-1:0] din,
	output logic         vout,
	output logic [W-1:0] dout
);
	logic [W-1:0] d_s [D];
	logic [D-1:0] v_s;

	genvar k;
	for (k = 0; k < D; k++) begin : g_tap
		logic         v_in;
		logic [W-1:0] d_in;
		if (k == 0) begin : g_first
			assign v_in = vin;
			assign d_in = din;
		end else begin : g_next
			assign v_in = v_s[k-1];
			assign d_in = d_s[k-1];
		end
		// valid bit of this tap
		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				v_s[k] <= 1'b0;
			end else begin
				v_s[k] <= v_in;
			end
		end
		// payload of this tap
		always_ff @(posedge clk) begin
			d_s[k] <= d_in;
		end
	end

	assign vout = v_s[D-1];
	assign dout = d_s[D-1];
endmodule
`default_nettype wire

### hw/rtl/cci_mul.sv
// pipelined unsigned multiplier, one operand slice per stage
`default_nettype none
module cci_mul #(
	parameter int WA = cci_pkg::COORD_BITS_DEF,
	parameter int WB = cci_pkg::COORD_BITS_DEF,
	parameter int CW = cci_pkg::MUL_CHUNK
) (
	input  logic            clk,
	input  logic [WA-1:0]   a,
	input  logic [WB-1:0]   b,
	output logic [WA+WB-1:0] p
);
	localparam int NCH = (WB + CW - 1) / CW;
	localparam int BW  = NCH * CW;
	localparam int PW  = WA + WB;

	logic [WA-1:0] a_s   [NCH];
	logic [BW-1:0] b_s   [NCH];
	logic [PW-1:0] acc_s [NCH];
	logic [BW-1:0] b_ext;

	assign b_ext = BW'(b);

	genvar k;
	for (k = 0; k < NCH; k++) begin : g_stage
		logic [WA-1:0]    a_in;
		logic [BW-1:0]    b_in;
		logic [PW-1:0]    acc_in;
		logic [WA+CW-1:0] part;
		if (k == 0) begin : g_first
			assign a_in   = a;
			assign b_in   = b_ext;
			assign acc_in = '0;
		end else begin : g_next
			assign a_in   = a_s[k-1];
			assign b_in   = b_s[k-1];
			assign acc_in = acc_s[k-1];
		end
		// partial product of one slice, added at its weight
		assign part = (WA+CW)'(a_in) * (WA+CW)'(b_in[k*CW +: CW]);
		always_ff @(posedge clk) begin
			acc_s[k] <= acc_in + (PW'(part) << (k * CW));
		end
		if (k < NCH - 1) begin : g_carry
			always_ff @(posedge clk) begin
				a_s[k] <= a_in;
				b_s[k] <= b_in;
			end
		end
	end

	assign p = acc_s[NCH-1];
endmodule
`default_nettype wire

### hw/rtl/cci_sqrt.sv
// pipelined integer square root, one root bit per stage
`default_nettype none
module cci_sqrt #(
	parameter int NW = 4 * cci_pkg::COORD_BITS_DEF
) (
	input  logic            clk,
	input  logic [NW-1:0]   n,
	output logic [NW/2-1:0] root
);
	localparam int HW = NW / 2;
	localparam int RW = HW + 2;

	logic [NW-1:0] n_s    [HW];
	logic [RW-1:0] rem_s  [HW];
	logic [HW-1:0] root_s [HW];

	genvar k;
	for (k = 0; k < HW; k++) begin : g_stage
		logic [NW-1:0] n_in;
		logic [RW-1:0] rem_in;
		logic [HW-1:0] root_in;
		logic [RW-1:0] rem_x;
		logic [RW-1:0] trial;
		if (k == 0) begin : g_first
			assign n_in    = n;
			assign rem_in  = '0;
			assign root_in = '0;
		end else begin : g_next
			assign n_in    = n_s[k-1];
			assign rem_in  = rem_s[k-1];
			assign root_in = root_s[k-1];
		end
		// bring down two radicand bits and try the next root bit
		assign rem_x = {rem_in[RW-3:0], n_in[NW-1 -: 2]};
		assign trial = {root_in, 2'b01};
		always_ff @(posedge clk) begin
			n_s[k] <= n_in << 2;
			if (rem_x >= trial) begin
				rem_s[k]  <= rem_x - trial;
				root_s[k] <= {root_in[HW-2:0], 1'b1};
			end else begin
				rem_s[k]  <= rem_x;
				root_s[k] <= {root_in[HW-2:0], 1'b0};
			end
		end
	end

	assign root = root_s[HW-1];
endmodule
`default_nettype wire

### hw/rtl/cci_div.sv
// pipelined restoring divider with quotient clamp, one quotient bit per stage
`default_nettype none
module cci_div #(
	parameter int NUMW = 3 * cci_pkg::COORD_BITS_DEF,
	parameter int DENW = 2 * cci_pkg::COORD_BITS_DEF + 2,
	parameter int QB   = cci_pkg::QUOT_BITS
) (
	input  logic            clk,
	input  logic [NUMW-1:0] num,
	input  logic [DENW-1:0] den,
	output logic [QB-1:0]   q
);
	localparam int NP = NUMW + QB;
	localparam logic [QB-1:0] CLAMP = QB'(1) << (QB - 1);

	logic [NP-1:0]   numx;
	logic [NUMW-1:0] hi;
	logic            ovf_s0;
	logic [DENW-1:0] rem_s0;
	logic [QB-1:0]   lo_s0;
	logic [DENW-1:0] den_s0;

	logic [DENW-1:0] rem_s [QB];
	logic [QB-1:0]   lo_s  [QB];
	logic [QB-1:0]   q_s   [QB];
	logic [DENW-1:0] den_s [QB];
	logic            ovf_s [QB];

	assign numx = NP'(num);
	assign hi   = numx[NP-1:QB];

	// quotient too large for the kept bits
	always_ff @(posedge clk) begin
		ovf_s0 <= NP'(hi) >= NP'(den);
		rem_s0 <= DENW'(hi);
		lo_s0  <= numx[QB-1:0];
		den_s0 <= den;
	end

	genvar k;
	for (k = 0; k < QB; k++) begin : g_stage
		logic [DENW-1:0] rem_in;
		logic [QB-1:0]   lo_in;
		logic [QB-1:0]   q_in;
		logic [DENW-1:0] den_in;
		logic            ovf_in;
		logic [DENW:0]   rem_x;
		logic [DENW:0]   diff;
		logic            ge;
		if (k == 0) begin : g_first
			assign rem_in = rem_s0;
			assign lo_in  = lo_s0;
			assign q_in   = '0;
			assign den_in = den_s0;
			assign ovf_in = ovf_s0;
		end else begin : g_next
			assign rem_in = rem_s[k-1];
			assign lo_in  = lo_s[k-1];
			assign q_in   = q_s[k-1];
			assign den_in = den_s[k-1];
			assign ovf_in = ovf_s[k-1];
		end
		// shift in one dividend bit and subtract when it fits
		assign rem_x = {rem_in, lo_in[QB-1]};
		assign diff  = rem_x - (DENW+1)'(den_in);
		assign ge    = rem_x >= (DENW+1)'(den_in);
		always_ff @(posedge clk) begin
			rem_s[k] <= ge ? diff[DENW-1:0] : rem_x[DENW-1:0];
			lo_s[k]  <= lo_in << 1;
			q_s[k]   <= {q_in[QB-2:0], ge};
			den_s[k] <= den_in;
			ovf_s[k] <= ovf_in;
		end
	end

	// clamp the magnitude
	always_ff @(posedge clk) begin
		q <= (ovf_s[QB-1] || (q_s[QB-1] > CLAMP)) ? CLAMP : q_s[QB-1];
	end
endmodule
`default_nettype wire

### hw/rtl/circle_circle_intersection.sv
// top level of the two-circle intersection pipeline
// Two circles (center and radius, fixed point) go in with start; one result comes out
// per transaction with done high for one cycle, in order. busy is always low: a new
// transaction can enter every clock cycle and the receiver cannot stall the pipeline.
// The square root of the 4C-bit product (C = COORD_BITS) and the dividers resolve
// one bit per stage. The math is scale free, so the 16 fraction bits of the format
// do not enter the logic. When the centers coincide, the circles are apart or one
// lies inside the other, intersects and all other result fields are zero; touching
// circles give tangent high and point a equal to point b.
`default_nettype none
module circle_circle_intersection #(
	parameter int COORD_BITS = cci_pkg::COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	output logic                         busy,
	output logic                         done,
	input  logic signed [COORD_BITS-1:0] first_center_x,
	input  logic signed [COORD_BITS-1:0] first_center_y,
	input  logic        [COORD_BITS-2:0] first_radius,
	input  logic signed [COORD_BITS-1:0] second_center_x,
	input  logic signed [COORD_BITS-1:0] second_center_y,
	input  logic        [COORD_BITS-2:0] second_radius,
	output logic                         intersects,
	output logic                         tangent,
	output logic signed [COORD_BITS-1:0] point_a_x,
	output logic signed [COORD_BITS-1:0] point_a_y,
	output logic signed [COORD_BITS-1:0] point_b_x,
	output logic signed [COORD_BITS-1:0] point_b_y
);
	localparam int C    = COORD_BITS;
	localparam int CH   = cci_pkg::MUL_CHUNK;
	localparam int QB   = cci_pkg::QUOT_BITS;
	localparam int SW   = 2 * C + 1;
	localparam int PW2  = 2 * C;
	localparam int TW   = 2 * C + 2;
	localparam int KW   = 4 * C;
	localparam int QW   = 2 * C;
	localparam int DENW = SW + 1;
	localparam int FW   = ((C > QB) ? C : QB) + 3;
	localparam int LM1  = (C + CH - 1) / CH;
	localparam int LK   = (PW2 + CH - 1) / CH;
	localparam int LM2  = (C + CH - 1) / CH;
	localparam int WA_S = 2 + 4 * C;
	localparam int WB_S = 3 + TW + SW + WA_S;
	localparam int WC_S = 3 + SW + 2 + 2 * C;
	localparam int WD_S = 5 + 2 * C;

	// sign-applied quotient at full sum width
	function automatic logic [FW-1:0] apply_sign(input logic [QB-1:0] v, input logic neg);
		logic [FW-1:0] e;
		e = FW'(v);
		return neg ? (FW'(0) - e) : e;
	endfunction

	// saturate to the signed coordinate range
	function automatic logic [C-1:0] sat(input logic [FW-1:0] v);
		logic signed [FW-1:0] vs;
		logic signed [FW-1:0] hi;
		logic signed [FW-1:0] lo;
		vs = v;
		hi = (FW'(1) << (C - 1)) - FW'(1);
		lo = -hi - FW'(1);
		if (vs > hi) begin
			return hi[C-1:0];
		end else if (vs < lo) begin
			return lo[C-1:0];
		end
		return vs[C-1:0];
	endfunction

	// stage 1 inputs: center differences and radius sum and difference
	logic signed [C:0] ex;
	logic signed [C:0] ey;
	logic [C:0]        ex_abs;
	logic [C:0]        ey_abs;
	logic              vld_s1;
	logic [C-1:0]      ax0_s1, ay0_s1, wx_s1, wy_s1, rs_s1;
	logic [C-2:0]      rd_s1, r0_s1, r1_s1;
	logic              sx_s1, sy_s1;

	assign busy   = 1'b0;
	assign ex     = (C+1)'(second_center_x) - (C+1)'(first_center_x);
	assign ey     = (C+1)'(second_center_y) - (C+1)'(first_center_y);
	assign ex_abs = ex[C] ? (C+1)'(-ex) : ex;
	assign ey_abs = ey[C] ? (C+1)'(-ey) : ey;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
		end else begin
			vld_s1 <= start && !busy;
		end
	end

	always_ff @(posedge clk) begin
		ax0_s1 <= first_center_x;
		ay0_s1 <= first_center_y;
		wx_s1  <= ex_abs[C-1:0];
		wy_s1  <= ey_abs[C-1:0];
		sx_s1  <= ex[C];
		sy_s1  <= ey[C];
		rs_s1  <= C'(first_radius) + C'(second_radius);
		rd_s1  <= (first_radius >= second_radius) ? (first_radius - second_radius)
		                                          : (second_radius - first_radius);
		r0_s1  <= first_radius;
		r1_s1  <= second_radius;
	end

	// squares of the differences and radii
	logic [2*C-1:0] wx2_m, wy2_m, pn_m, mn_m, r0q_m, r1q_m;
	logic           vld_m1;
	logic [WA_S-1:0] side_m1;

	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_wx (.clk(clk), .a(wx_s1), .b(wx_s1), .p(wx2_m));
	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_wy (.clk(clk), .a(wy_s1), .b(wy_s1), .p(wy2_m));
	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_pn (.clk(clk), .a(rs_s1), .b(rs_s1), .p(pn_m));
	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_mn (
		.clk(clk), .a(C'(rd_s1)), .b(C'(rd_s1)), .p(mn_m)
	);
	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_r0 (
		.clk(clk), .a(C'(r0_s1)), .b(C'(r0_s1)), .p(r0q_m)
	);
	cci_mul #(.WA(C), .WB(C), .CW(CH)) u_mul_r1 (
		.clk(clk), .a(C'(r1_s1)), .b(C'(r1_s1)), .p(r1q_m)
	);
	cci_delay #(.W(WA_S), .D(LM1)) u_dly_m1 (
		.clk(clk), .arst_n(arst_n), .vin(vld_s1),
		.din({sx_s1, sy_s1, wx_s1, wy_s1, ax0_s1, ay0_s1}),
		.vout(vld_m1), .dout(side_m1)
	);

	// stage 3: squared center distance
	logic            vld_s3;
	logic [SW-1:0]   s_s3;
	logic [PW2-1:0]  pn_s3, mn_s3, r0q_s3, r1q_s3;
	logic [WA_S-1:0] side_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s3 <= 1'b0;
		end else begin
			vld_s3 <= vld_m1;
		end
	end

	always_ff @(posedge clk) begin
		s_s3    <= SW'(wx2_m) + SW'(wy2_m);
		pn_s3   <= pn_m;
		mn_s3   <= mn_m;
		r0q_s3  <= r0q_m;
		r1q_s3  <= r1q_m;
		side_s3 <= side_m1;
	end

	// stage 4: decline and touch tests, terms of the radicand
	logic            vld_s4, dec_s4, touch_s4;
	logic [TW-1:0]   t_s4;
	logic [PW2-1:0]  r1q_s4, a_s4, b_s4;
	logic [SW-1:0]   s_s4;
	logic [WA_S-1:0] side_s4;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s4 <= 1'b0;
		end else begin
			vld_s4 <= vld_s3;
		end
	end

	always_ff @(posedge clk) begin
		dec_s4   <= (s_s3 == '0) || (s_s3 > SW'(pn_s3)) || (s_s3 < SW'(mn_s3));
		touch_s4 <= (s_s3 == SW'(pn_s3)) || (s_s3 == SW'(mn_s3));
		t_s4     <= TW'(r0q_s3) + TW'(s_s3);
		r1q_s4   <= r1q_s3;
		a_s4     <= PW2'(SW'(pn_s3) - s_s3);
		b_s4     <= PW2'(s_s3 - SW'(mn_s3));
		s_s4     <= s_s3;
		side_s4  <= side_s3;
	end

	// stage 5: magnitude and sign of the offset numerator
	logic            vld_s5, dec_s5, touch_s5, nneg_s5;
	logic [TW-1:0]   nn_s5;
	logic [PW2-1:0]  a_s5, b_s5;
	logic [SW-1:0]   s_s5;
	logic [WA_S-1:0] side_s5;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s5 <= 1'b0;
		end else begin
			vld_s5 <= vld_s4;
		end
	end

	always_ff @(posedge clk) begin
		nneg_s5  <= t_s4 < TW'(r1q_s4);
		nn_s5    <= (t_s4 >= TW'(r1q_s4)) ? (t_s4 - TW'(r1q_s4)) : (TW'(r1q_s4) - t_s4);
		dec_s5   <= dec_s4;
		touch_s5 <= touch_s4;
		a_s5     <= a_s4;
		b_s5     <= b_s4;
		s_s5     <= s_s4;
		side_s5  <= side_s4;
	end

	// radicand product and its square root
	logic [KW-1:0]   k_m;
	logic [QW-1:0]   q_r;
	logic            vld_q;
	logic [WB_S-1:0] side_q;
	logic            dec_q, touch_q, nneg_q, sx_q, sy_q;
	logic [TW-1:0]   nn_q;
	logic [SW-1:0]   s_q;
	logic [C-1:0]    wx_q, wy_q, ax0_q, ay0_q;

	cci_mul #(.WA(PW2), .WB(PW2), .CW(CH)) u_mul_k (.clk(clk), .a(a_s5), .b(b_s5), .p(k_m));
	cci_sqrt #(.NW(KW)) u_sqrt (.clk(clk), .n(k_m), .root(q_r));
	cci_delay #(.W(WB_S), .D(LK + QW)) u_dly_q (
		.clk(clk), .arst_n(arst_n), .vin(vld_s5),
		.din({dec_s5, touch_s5, nneg_s5, nn_s5, s_s5, side_s5}),
		.vout(vld_q), .dout(side_q)
	);
	assign {dec_q, touch_q, nneg_q, nn_q, s_q, sx_q, sy_q, wx_q, wy_q, ax0_q, ay0_q} = side_q;

	// numerators of the offset and of the perpendicular part
	logic [TW+C-1:0] num_ox, num_oy;
	logic [QW+C-1:0] num_mx, num_my;
	logic            vld_p;
	logic [WC_S-1:0] side_p;
	logic            dec_p, touch_p, nneg_p, sx_p, sy_p;
	logic [SW-1:0]   s_p;
	logic [C-1:0]    ax0_p, ay0_p;

	cci_mul #(.WA(TW), .WB(C), .CW(CH)) u_mul_ox (.clk(clk), .a(nn_q), .b(wx_q), .p(num_ox));
	cci_mul #(.WA(TW), .WB(C), .CW(CH)) u_mul_oy (.clk(clk), .a(nn_q), .b(wy_q), .p(num_oy));
	cci_mul #(.WA(QW), .WB(C), .CW(CH)) u_mul_mx (.clk(clk), .a(q_r), .b(wy_q), .p(num_mx));
	cci_mul #(.WA(QW), .WB(C), .CW(CH)) u_mul_my (.clk(clk), .a(q_r), .b(wx_q), .p(num_my));
	cci_delay #(.W(WC_S), .D(LM2)) u_dly_p (
		.clk(clk), .arst_n(arst_n), .vin(vld_q),
		.din({dec_q, touch_q, nneg_q, s_q, sx_q, sy_q, ax0_q, ay0_q}),
		.vout(vld_p), .dout(side_p)
	);
	assign {dec_p, touch_p, nneg_p, s_p, sx_p, sy_p, ax0_p, ay0_p} = side_p;

	// divisions by twice the squared distance
	logic [DENW-1:0] den_p;
	logic [QB-1:0]   q_ox, q_oy, q_mx, q_my;
	logic            vld_v;
	logic [WD_S-1:0] side_v;
	logic            dec_v, touch_v, nneg_v, sx_v, sy_v;
	logic [C-1:0]    ax0_v, ay0_v;

	assign den_p = {s_p, 1'b0};

	cci_div #(.NUMW(TW+C), .DENW(DENW), .QB(QB)) u_div_ox (
		.clk(clk), .num(num_ox), .den(den_p), .q(q_ox)
	);
	cci_div #(.NUMW(TW+C), .DENW(DENW), .QB(QB)) u_div_oy (
		.clk(clk), .num(num_oy), .den(den_p), .q(q_oy)
	);
	cci_div #(.NUMW(QW+C), .DENW(DENW), .QB(QB)) u_div_mx (
		.clk(clk), .num(num_mx), .den(den_p), .q(q_mx)
	);
	cci_div #(.NUMW(QW+C), .DENW(DENW), .QB(QB)) u_div_my (
		.clk(clk), .num(num_my), .den(den_p), .q(q_my)
	);
	cci_delay #(.W(WD_S), .D(QB + 2)) u_dly_v (
		.clk(clk), .arst_n(arst_n), .vin(vld_p),
		.din({dec_p, touch_p, nneg_p, sx_p, sy_p, ax0_p, ay0_p}),
		.vout(vld_v), .dout(side_v)
	);
	assign {dec_v, touch_v, nneg_v, sx_v, sy_v, ax0_v, ay0_v} = side_v;

	// stage 6: center plus offset plus or minus perpendicular part
	logic [FW-1:0] cx, cy, ox, oy, mx, my;
	logic          vld_s6, dec_s6, touch_s6;
	logic [FW-1:0] pax_s6, pay_s6, pbx_s6, pby_s6;

	assign cx = {{(FW-C){ax0_v[C-1]}}, ax0_v};
	assign cy = {{(FW-C){ay0_v[C-1]}}, ay0_v};
	assign ox = apply_sign(q_ox, sx_v ^ nneg_v);
	assign oy = apply_sign(q_oy, sy_v ^ nneg_v);
	assign mx = apply_sign(q_mx, !sy_v);
	assign my = apply_sign(q_my, sx_v);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s6 <= 1'b0;
		end else begin
			vld_s6 <= vld_v;
		end
	end

	always_ff @(posedge clk) begin
		dec_s6   <= dec_v;
		touch_s6 <= touch_v;
		pax_s6   <= cx + ox + mx;
		pay_s6   <= cy + oy + my;
		pbx_s6   <= cx + ox - mx;
		pby_s6   <= cy + oy - my;
	end

	// stage 7: saturate and zero declined results
	logic         done_s7, int_s7, tan_s7;
	logic [C-1:0] pax_s7, pay_s7, pbx_s7, pby_s7;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_s7 <= 1'b0;
		end else begin
			done_s7 <= vld_s6;
		end
	end

	always_ff @(posedge clk) begin
		int_s7 <= !dec_s6;
		tan_s7 <= !dec_s6 && touch_s6;
		pax_s7 <= dec_s6 ? '0 : sat(pax_s6);
		pay_s7 <= dec_s6 ? '0 : sat(pay_s6);
		pbx_s7 <= dec_s6 ? '0 : sat(pbx_s6);
		pby_s7 <= dec_s6 ? '0 : sat(pby_s6);
	end

	assign done       = done_s7;
	assign intersects = int_s7;
	assign tangent    = tan_s7;
	assign point_a_x  = pax_s7;
	assign point_a_y  = pay_s7;
	assign point_b_x  = pbx_s7;
	assign point_b_y  = pby_s7;
endmodule
`default_nettype wire

### hw/rtl/cci_checker.sv
// port-level assertions for the circle intersection block and their bind
`default_nettype none
`include "circle_circle_intersection_macros.svh"
module cci_checker #(
	parameter int COORD_BITS = cci_pkg::COORD_BITS_DEF
) (
	input logic                  clk,
	input logic                  arst_n,
	input logic                  busy,
	input logic                  done,
	input logic                  intersects,
	input logic                  tangent,
	input logic [COORD_BITS-1:0] point_a_x,
	input logic [COORD_BITS-1:0] point_a_y,
	input logic [COORD_BITS-1:0] point_b_x,
	input logic [COORD_BITS-1:0] point_b_y
);
	// the pipeline never refuses a transaction
	`CCI_ASSERT_ALWAYS(a_never_busy, !busy, "busy raised")
	// touching circles are a valid intersection
	`CCI_ASSERT_IMPLIES(a_tan_int, done && tangent, intersects, "tangent without intersects")
	// touching gives the same point twice
	`CCI_ASSERT_IMPLIES(a_tan_same, done && tangent, (point_a_x == point_b_x) && (point_a_y == point_b_y), "tangent points differ")
	// declined results carry zeros
	`CCI_ASSERT_IMPLIES(a_dec_zero, done && !intersects, !tangent && (point_a_x == '0) && (point_a_y == '0) && (point_b_x == '0) && (point_b_y == '0), "declined result not zero")
endmodule

bind circle_circle_intersection cci_checker #(.COORD_BITS(COORD_BITS)) u_cci_checker (.*);
`default_nettype wire
